// ===== rtl/fvnh_pkg.sv =====
// ----------------------------------------------------------------------------
// fvnh_pkg
// Shared types and constants of the fractal value noise height block.
// ----------------------------------------------------------------------------
`default_nettype none

package fvnh_pkg;

  localparam int FREQ_FRAC = 24;
  localparam int CORNER_W  = 24;
  localparam int HASH_W    = 53;
  localparam int MIX_W     = 40;
  localparam int OCT_W     = 4;
  localparam int CELL_LAT  = 8;
  localparam int DIV_STEP  = 6;

  localparam logic [31:0] HASH_X_MUL    = 32'd374761393;
  localparam logic [31:0] HASH_Z_MUL    = 32'd668265263;
  localparam logic [63:0] SEED_MUL      = 64'd1442695040888963407;
  localparam logic [63:0] OCT_SEED_STEP = 64'd1013904223;
  localparam logic [63:0] SEED_STEP_MUL = SEED_MUL * OCT_SEED_STEP;
  localparam logic [30:0] MIX_MUL       = 31'd1274126177;
  localparam logic [25:0] LACUNARITY    = 26'd34057748;

  localparam logic [31:0] BASE_FREQ_RST = 32'd16777216;
  localparam logic [31:0] GAIN_RST      = 32'd65536;

  localparam logic [1:0] REG_OCTAVES = 2'd0;
  localparam logic [1:0] REG_FREQ    = 2'd1;
  localparam logic [1:0] REG_SEED    = 2'd2;
  localparam logic [1:0] REG_GAIN    = 2'd3;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_z;
  } point_t;

endpackage

`default_nettype wire

// ===== rtl/fvnh_cfg.sv =====
// ----------------------------------------------------------------------------
// fvnh_cfg
// Configuration registers and the per-octave frequency and seed tables,
// refilled by a short sequence after reset and after every write.
// ----------------------------------------------------------------------------
`default_nettype none

module fvnh_cfg #(
  parameter int MAX_OCTAVES = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [63:0]                cfg_data,
  output logic                            busy,
  output logic [fvnh_pkg::OCT_W-1:0]      octaves,
  output logic [31:0]                     gain,
  output logic [31:0]                     freq_tab [MAX_OCTAVES],
  output logic [fvnh_pkg::HASH_W-1:0]     smul_tab [MAX_OCTAVES]
);
  import fvnh_pkg::*;

  localparam int LAST = 4 + MAX_OCTAVES;
  localparam int SW   = $clog2(LAST + 1);
  localparam int IW   = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;

  localparam logic [SW-1:0] STEP_IDLE = SW'(0);
  localparam logic [SW-1:0] STEP_LO   = SW'(1);
  localparam logic [SW-1:0] STEP_X1   = SW'(2);
  localparam logic [SW-1:0] STEP_SUM  = SW'(4);
  localparam logic [SW-1:0] STEP_FILL = SW'(5);
  localparam logic [SW-1:0] STEP_LAST = SW'(LAST);

  logic [OCT_W-1:0]  oct_r;
  logic [31:0]       freq_r;
  logic [63:0]       seed_r;
  logic [31:0]       gain_r;
  logic [SW-1:0]     step_r;
  logic [63:0]       pp0_r;
  logic [31:0]       pp1_r;
  logic [31:0]       pp2_r;
  logic [31:0]       cur_f_r;
  logic [63:0]       cur_s_r;
  logic [31:0]       freq_tab_r [MAX_OCTAVES];
  logic [HASH_W-1:0] smul_tab_r [MAX_OCTAVES];

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [57:0] f_prod;
  logic [31:0] f_nxt;
  logic [IW-1:0] fill_idx;
  logic [SW-1:0] fill_ofs;

  // shared multiplier for the seed product, low half and cross terms
  always_comb begin
    case (step_r)
      STEP_LO: begin
        mul_a = seed_r[31:0];
        mul_b = SEED_MUL[31:0];
      end
      STEP_X1: begin
        mul_a = seed_r[31:0];
        mul_b = SEED_MUL[63:32];
      end
      default: begin
        mul_a = seed_r[63:32];
        mul_b = SEED_MUL[31:0];
      end
    endcase
    mul_p    = 64'(mul_a) * 64'(mul_b);
    f_prod   = 58'(cur_f_r) * 58'(LACUNARITY);
    f_nxt    = (|f_prod[57:56]) ? 32'hFFFF_FFFF : f_prod[55:24];
    fill_ofs = step_r - STEP_FILL;
    fill_idx = fill_ofs[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_r  <= '0;
      freq_r <= BASE_FREQ_RST;
      seed_r <= '0;
      gain_r <= GAIN_RST;
      step_r <= STEP_LO;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_OCTAVES: oct_r  <= cfg_data[OCT_W-1:0];
          REG_FREQ:    freq_r <= cfg_data[31:0];
          REG_SEED:    seed_r <= cfg_data;
          REG_GAIN:    gain_r <= cfg_data[31:0];
          default: begin
          end
        endcase
        step_r <= STEP_LO;
      end else if (step_r != STEP_IDLE) begin
        step_r <= (step_r == STEP_LAST) ? STEP_IDLE : step_r + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (step_r)
      STEP_LO: begin
        pp0_r   <= mul_p;
        cur_f_r <= freq_r;
      end
      STEP_X1: pp1_r <= mul_p[31:0];
      STEP_SUM: cur_s_r <= pp0_r + {pp1_r + pp2_r, 32'd0};
      STEP_IDLE: begin
      end
      default: begin
        if (step_r >= STEP_FILL) begin
          freq_tab_r[fill_idx] <= cur_f_r;
          smul_tab_r[fill_idx] <= cur_s_r[HASH_W-1:0];
          cur_f_r              <= f_nxt;
          cur_s_r              <= cur_s_r + SEED_STEP_MUL;
        end else begin
          pp2_r <= mul_p[31:0];
        end
      end
    endcase
  end

  assign cfg_ready = 1'b1;
  assign busy      = (step_r != STEP_IDLE);
  assign octaves   = oct_r;
  assign gain      = gain_r;
  assign freq_tab  = freq_tab_r;
  assign smul_tab  = smul_tab_r;

  a_write_refill: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> busy)
    else $error("table refill not started after config write");

endmodule

`default_nettype wire

// ===== rtl/fvnh_cell.sv =====
// ----------------------------------------------------------------------------
// fvnh_cell
// One octave of value noise: scales the point, hashes four lattice corners,
// blends them and folds the octave into the running sum.
// ----------------------------------------------------------------------------
`default_nettype none

module fvnh_cell #(
  parameter int FRAC_BITS = 16,
  parameter int ACC_W     = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire logic [31:0]                    freq,
  input  wire logic [fvnh_pkg::HASH_W-1:0]    smul,
  input  wire fvnh_pkg::point_t               pt_i,
  input  wire logic [ACC_W-1:0]               acc_i,
  output fvnh_pkg::point_t                    pt_o,
  output logic [ACC_W-1:0]                    acc_o
);
  import fvnh_pkg::*;

  localparam int SH    = FRAC_BITS + FREQ_FRAC;
  localparam int EXT_W = SH + 32;

  logic               vld_r [CELL_LAT];
  logic signed [31:0] px_r  [CELL_LAT];
  logic signed [31:0] pz_r  [CELL_LAT];
  logic [ACC_W-1:0]   acc_r [CELL_LAT];

  logic signed [64:0] prx_r, prz_r;
  logic [31:0]        hx0_r, hx1_r, hz0_r, hz1_r;
  logic [15:0]        t2x_r, t2z_r;
  logic [17:0]        wx_r, wz_r;
  logic [16:0]        u3_r, v3_r, u4_r, v4_r, u5_r, v5_r;
  logic [MIX_W-1:0]   g_r  [4];
  logic [MIX_W-1:0]   pl_r [4];
  logic [19:0]        ph_r [4];
  logic [CORNER_W-1:0] crn_r [4];
  logic signed [42:0] e1_r, e2_r, e1_7_r, e2_7_r;
  logic [33:0]        uv_r;
  logic signed [25:0] dd_r;
  logic [CORNER_W-1:0] a6_r, a7_r;
  logic signed [60:0] e3_r;

  logic signed [EXT_W-1:0] ex_x, ex_z;
  logic [31:0]        xi, zi, xn, zn;
  logic [15:0]        tx, tz;
  logic [31:0]        ttx, ttz;
  logic [33:0]        spx, spz;
  logic [31:0]        hs [4];
  logic [HASH_W-1:0]  hh [4];
  logic [MIX_W-1:0]   mx [4];
  logic signed [24:0] ba, ca;
  logic signed [25:0] dd;
  logic signed [63:0] nsum;
  logic [CORNER_W-1:0] nv;

  always_comb begin
    ex_x = EXT_W'(prx_r);
    ex_z = EXT_W'(prz_r);
    xi   = ex_x[SH +: 32];
    zi   = ex_z[SH +: 32];
    xn   = xi + 32'd1;
    zn   = zi + 32'd1;
    tx   = prx_r[SH-1 -: 16];
    tz   = prz_r[SH-1 -: 16];
    ttx  = {16'd0, tx} * {16'd0, tx};
    ttz  = {16'd0, tz} * {16'd0, tz};
    spx  = {18'd0, t2x_r} * {16'd0, wx_r};
    spz  = {18'd0, t2z_r} * {16'd0, wz_r};
    hs[0] = hx0_r + hz0_r;
    hs[1] = hx1_r + hz0_r;
    hs[2] = hx0_r + hz1_r;
    hs[3] = hx1_r + hz1_r;
    for (int k = 0; k < 4; k++) begin
      hh[k] = HASH_W'(hs[k]) + smul;
      mx[k] = pl_r[k] + {ph_r[k], 20'd0};
    end
    ba   = $signed({1'b0, crn_r[1]}) - $signed({1'b0, crn_r[0]});
    ca   = $signed({1'b0, crn_r[2]}) - $signed({1'b0, crn_r[0]});
    dd   = $signed({2'b0, crn_r[0]}) - $signed({2'b0, crn_r[1]})
         - $signed({2'b0, crn_r[2]}) + $signed({2'b0, crn_r[3]});
    nsum = $signed({8'd0, a7_r, 32'd0}) + (64'(e1_7_r) <<< 16)
         + (64'(e2_7_r) <<< 16) + 64'(e3_r);
    nv   = nsum[63] ? '0 : nsum[55:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < CELL_LAT; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else begin
      vld_r[0] <= pt_i.valid;
      for (int s = 1; s < CELL_LAT; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    px_r[0]  <= pt_i.pos_x;
    pz_r[0]  <= pt_i.pos_z;
    acc_r[0] <= acc_i;
    for (int s = 1; s < CELL_LAT; s++) begin
      px_r[s] <= px_r[s-1];
      pz_r[s] <= pz_r[s-1];
    end
    for (int s = 1; s < CELL_LAT - 1; s++) begin
      acc_r[s] <= acc_r[s-1];
    end
    acc_r[CELL_LAT-1] <= en ? {acc_r[CELL_LAT-2][ACC_W-2:0], 1'b0} + ACC_W'(nv)
                            : acc_r[CELL_LAT-2];

    // scale
    prx_r <= $signed(pt_i.pos_x) * $signed({1'b0, freq});
    prz_r <= $signed(pt_i.pos_z) * $signed({1'b0, freq});
    // lattice hash terms and fraction square
    hx0_r <= xi * HASH_X_MUL;
    hx1_r <= xn * HASH_X_MUL;
    hz0_r <= zi * HASH_Z_MUL;
    hz1_r <= zn * HASH_Z_MUL;
    t2x_r <= ttx[31:16];
    t2z_r <= ttz[31:16];
    wx_r  <= 18'd196608 - {1'b0, tx, 1'b0};
    wz_r  <= 18'd196608 - {1'b0, tz, 1'b0};
    // smoothstep and seed mix
    u3_r <= spx[32:16];
    v3_r <= spz[32:16];
    for (int k = 0; k < 4; k++) begin
      g_r[k]   <= hh[k][MIX_W-1:0] ^ hh[k][HASH_W-1:13];
      pl_r[k]  <= {20'd0, g_r[k][19:0]} * {9'd0, MIX_MUL};
      ph_r[k]  <= g_r[k][39:20] * MIX_MUL[19:0];
      crn_r[k] <= mx[k][23:0] ^ mx[k][39:16];
    end
    u4_r <= u3_r;
    v4_r <= v3_r;
    u5_r <= u4_r;
    v5_r <= v4_r;
    // bilinear blend
    e1_r <= ba * $signed({1'b0, u5_r});
    e2_r <= ca * $signed({1'b0, v5_r});
    uv_r <= {17'd0, u5_r} * {17'd0, v5_r};
    dd_r <= dd;
    a6_r <= crn_r[0];
    e3_r   <= dd_r * $signed({1'b0, uv_r});
    e1_7_r <= e1_r;
    e2_7_r <= e2_r;
    a7_r   <= a6_r;
  end

  assign pt_o  = '{valid: vld_r[CELL_LAT-1], pos_x: px_r[CELL_LAT-1],
                   pos_z: pz_r[CELL_LAT-1]};
  assign acc_o = acc_r[CELL_LAT-1];

endmodule

`default_nettype wire

// ===== rtl/fvnh_div.sv =====
// ----------------------------------------------------------------------------
// fvnh_div
// Pipelined restoring divider by a narrow divisor, a few quotient bits per
// stage.
// ----------------------------------------------------------------------------
`default_nettype none

module fvnh_div #(
  parameter int DVD_W = 41,
  parameter int DVS_W = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_vld,
  input  wire logic [DVD_W-1:0] dvd,
  input  wire logic [DVS_W-1:0] dvs,
  output logic                  out_vld,
  output logic [DVD_W-1:0]      quo
);
  import fvnh_pkg::*;

  localparam int STG   = (DVD_W + DIV_STEP - 1) / DIV_STEP;
  localparam int PAD_W = STG * DIV_STEP;

  logic             vld_r [STG];
  logic [PAD_W-1:0] num_r [STG];
  logic [PAD_W-1:0] quo_r [STG];
  logic [DVS_W-1:0] rem_r [STG];

  for (genvar s = 0; s < STG; s++) begin : g_stg
    logic             vin;
    logic [PAD_W-1:0] nin;
    logic [PAD_W-1:0] qin;
    logic [DVS_W-1:0] rin;
    logic [PAD_W-1:0] nm;
    logic [PAD_W-1:0] qv;
    logic [DVS_W-1:0] rv;
    logic [DVS_W:0]   rt;

    if (s == 0) begin : g_head
      assign vin = in_vld;
      assign nin = PAD_W'(dvd);
      assign qin = '0;
      assign rin = '0;
    end else begin : g_body
      assign vin = vld_r[s-1];
      assign nin = num_r[s-1];
      assign qin = quo_r[s-1];
      assign rin = rem_r[s-1];
    end

    always_comb begin
      nm = nin;
      qv = qin;
      rv = rin;
      rt = '0;
      for (int i = 0; i < DIV_STEP; i++) begin
        rt = {rv, nm[PAD_W-1]};
        nm = {nm[PAD_W-2:0], 1'b0};
        if (rt >= {1'b0, dvs}) begin
          rt = rt - {1'b0, dvs};
          qv = {qv[PAD_W-2:0], 1'b1};
        end else begin
          qv = {qv[PAD_W-2:0], 1'b0};
        end
        rv = rt[DVS_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      num_r[s] <= nm;
      quo_r[s] <= qv;
      rem_r[s] <= rv;
    end
  end

  assign out_vld = vld_r[STG-1];
  assign quo     = quo_r[STG-1][DVD_W-1:0];

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[STG-1] && (dvs != '0)) |-> (rem_r[STG-1] < dvs))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

// ===== rtl/fractal_value_noise_height.sv =====
// ----------------------------------------------------------------------------
// fractal_value_noise_height
// Fractal value noise terrain height: one point in, one height out per
// transfer, a row of octave cells followed by gain and normalization.
// ----------------------------------------------------------------------------
// One point is taken in every cycle while busy is low; each point gives one
// height on out_valid, in order, and the receiver cannot stall. Each octave
// cell is an 8-stage pipeline and the final normalization divides over a
// pipelined 6-bit-per-stage divider. After reset and after every
// configuration write busy stays high while the per-octave frequency and
// seed tables are rebuilt.
`default_nettype none

module fractal_value_noise_height #(
  parameter int MAX_OCTAVES = 8,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_z,
  output logic                    out_valid,
  output logic signed [31:0]      out_height_out,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [63:0]        cfg_data
);
  import fvnh_pkg::*;

  localparam int ACC_W   = CORNER_W + MAX_OCTAVES;
  localparam int PROD_W  = ACC_W + 32;
  localparam int DVD_W   = PROD_W + 1 - FREQ_FRAC;
  localparam int DVS_W   = MAX_OCTAVES;
  localparam int DIV_STG = (DVD_W + DIV_STEP - 1) / DIV_STEP;
  localparam int LAT     = CELL_LAT * MAX_OCTAVES + 3 + DIV_STG;

  logic [OCT_W-1:0]  octaves;
  logic [OCT_W-1:0]  n_eff;
  logic [31:0]       gain;
  logic [31:0]       freq_tab [MAX_OCTAVES];
  logic [HASH_W-1:0] smul_tab [MAX_OCTAVES];
  logic [MAX_OCTAVES-1:0] oct_en;

  point_t           pt_c  [MAX_OCTAVES+1];
  logic [ACC_W-1:0] acc_c [MAX_OCTAVES+1];

  logic              neg;
  logic [31:0]       mag;
  logic [DVS_W-1:0]  dvs;
  logic [DVS_W:0]    pow_n;
  logic [PROD_W:0]   p_adj;
  logic              t1_vld_r, t2_vld_r;
  logic [PROD_W-1:0] prod_r;
  logic [DVD_W-1:0]  dvd_r;
  logic              q_vld;
  logic [DVD_W-1:0]  quo;
  logic [31:0]       h_nxt;
  logic              out_valid_r;
  logic [31:0]       out_height_r;

  fvnh_cfg #(
    .MAX_OCTAVES(MAX_OCTAVES)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .octaves   (octaves),
    .gain      (gain),
    .freq_tab  (freq_tab),
    .smul_tab  (smul_tab)
  );

  assign n_eff = (octaves > OCT_W'(MAX_OCTAVES)) ? OCT_W'(MAX_OCTAVES) : octaves;

  assign pt_c[0]  = '{valid: start && !busy, pos_x: in_pos_x, pos_z: in_pos_z};
  assign acc_c[0] = '0;

  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
    assign oct_en[k] = (OCT_W'(k) < n_eff);

    fvnh_cell #(
      .FRAC_BITS(FRAC_BITS),
      .ACC_W    (ACC_W)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (oct_en[k]),
      .freq  (freq_tab[k]),
      .smul  (smul_tab[k]),
      .pt_i  (pt_c[k]),
      .acc_i (acc_c[k]),
      .pt_o  (pt_c[k+1]),
      .acc_o (acc_c[k+1])
    );
  end

  // gain and normalization, magnitude rounded up (away from zero) for a negative gain
  always_comb begin
    neg   = gain[31];
    mag   = neg ? (32'd0 - gain) : gain;
    pow_n = (DVS_W+1)'(1) << n_eff;
    dvs   = DVS_W'(pow_n - (DVS_W+1)'(1));
    p_adj = neg ? ((PROD_W+1)'(prod_r) + (PROD_W+1)'({dvs - DVS_W'(1), 24'hFF_FFFF}))
                : (PROD_W+1)'(prod_r);
    if (n_eff == '0) begin
      h_nxt = '0;
    end else if (neg) begin
      h_nxt = (quo > DVD_W'(33'h0_8000_0000)) ? 32'h8000_0000 : (32'd0 - quo[31:0]);
    end else begin
      h_nxt = (quo > DVD_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quo[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_vld_r    <= 1'b0;
      t2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      t1_vld_r    <= pt_c[MAX_OCTAVES].valid;
      t2_vld_r    <= t1_vld_r;
      out_valid_r <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    prod_r       <= PROD_W'(acc_c[MAX_OCTAVES]) * PROD_W'(mag);
    dvd_r        <= p_adj[PROD_W:FREQ_FRAC];
    out_height_r <= h_nxt;
  end

  fvnh_div #(
    .DVD_W(DVD_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (t2_vld_r),
    .dvd     (dvd_r),
    .dvs     (dvs),
    .out_vld (q_vld),
    .quo     (quo)
  );

  assign out_valid      = out_valid_r;
  assign out_height_out = out_height_r;

  a_out_from_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without a matching input transfer");

  a_zero_oct: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (n_eff == '0)) |-> (out_height_out == '0))
    else $error("nonzero height with no octaves");

endmodule

`default_nettype wire
